// ===== rtl/arena_wall_reflect_move_assert.svh =====
// Assertion macros for the RTL of the arena wall reflection block.
`ifndef ARENA_WALL_REFLECT_MOVE_ASSERT_SVH
`define ARENA_WALL_REFLECT_MOVE_ASSERT_SVH

// Same-cycle implication, checked at every clock edge outside reset.
`define AWRM_ASSERT_IMPL(label, cond, expr) \
   label: assert property (@(posedge clock) disable iff (reset) (cond) |-> (expr)) \
      else $error("awrm assertion failed");

// Next-cycle implication, checked at every clock edge outside reset.
`define AWRM_ASSERT_NEXT(label, cond, expr) \
   label: assert property (@(posedge clock) disable iff (reset) (cond) |=> (expr)) \
      else $error("awrm assertion failed");

`endif

// ===== rtl/awrm_pkg.sv =====
`timescale 1ns / 1ps
package awrm_pkg;

   typedef enum logic [1:0] {
      CSR_X_MAX    = 2'd0,
      CSR_Y_MAX    = 2'd1,
      CSR_OBSTACLE = 2'd2,
      CSR_UNUSED   = 2'd3
   } csr_index_type;

   typedef enum logic [2:0] {
      WALL_LEFT   = 3'd0,
      WALL_TOP    = 3'd1,
      WALL_RIGHT  = 3'd2,
      WALL_BOTTOM = 3'd3,
      WALL_NONE   = 3'd4
   } wall_type;

   typedef enum logic [1:0] {
      OUT_FREE    = 2'd0,
      OUT_REFLECT = 2'd1,
      OUT_REVERSE = 2'd2,
      OUT_STAY    = 2'd3
   } outcome_type;

   localparam logic [14:0] X_MAX_RESET = 15'd9830;
   localparam logic [14:0] Y_MAX_RESET = 15'd4710;

   typedef struct packed {
      logic [14:0] x_max;
      logic [14:0] y_max;
      logic        block;
   } cfg_type;

   // Front end to ray stage: nearest wall per axis already chosen.
   typedef struct packed {
      logic signed [16:0] px;
      logic signed [16:0] py;
      logic signed [15:0] sx;
      logic signed [15:0] sy;
      logic signed [16:0] qx;
      logic signed [16:0] qy;
      logic               free;
      logic               rev_ok;
      logic               vx;
      logic               vy;
      logic               x_right;
      logic               y_bottom;
      logic [15:0]        num_x;
      logic [15:0]        num_y;
      logic [15:0]        dx;
      logic [15:0]        dy;
   } s2_type;

   // Ray stage to pick stage: cross products and mirrored candidates.
   typedef struct packed {
      logic signed [16:0] px;
      logic signed [16:0] py;
      logic signed [15:0] sx;
      logic signed [15:0] sy;
      logic signed [16:0] qx;
      logic signed [16:0] qy;
      logic               free;
      logic               rev_ok;
      logic               vx;
      logic               vy;
      logic               x_right;
      logic               y_bottom;
      logic [31:0]        prod_x;
      logic [31:0]        prod_y;
      logic signed [18:0] rfx;
      logic signed [18:0] rfy;
      logic               rfx_ok;
      logic               rfy_ok;
   } s3_type;

   function automatic logic in_arena(input logic signed [18:0] x,
                                     input logic signed [18:0] y,
                                     input cfg_type           cfg);
      logic signed [18:0] xm;
      logic signed [18:0] ym;
      xm = $signed({4'b0000, cfg.x_max});
      ym = $signed({4'b0000, cfg.y_max});
      return !cfg.block && (x > 19'sd0) && (x < xm) && (y > 19'sd0) && (y < ym);
   endfunction

endpackage

// ===== rtl/arena_wall_reflect_move.sv =====
`timescale 1ns / 1ps
// Moves a point inside the rectangular arena (0,0)..(x_max,y_max): to start plus move
// when that lands inside, else reflecting off the nearest wall ahead, reversing the
// move, or keeping the start when neither lands inside. A new transaction is taken on
// every cycle (busy stays low); each result appears on the rsp_ ports for one cycle,
// flagged by rsp_valid, after passing four register stages: sums and wall distances,
// per-axis nearest wall, the cross-multiply of ray parameters with mirroring, and the
// final selection. There is no back-pressure: the receiver must take every result in
// the cycle it appears. Write the csr_ registers only while no transaction is in flight.
module arena_wall_reflect_move
   import awrm_pkg::*;
(
   input  logic               clock,
   input  logic               reset,
   input  logic               start,
   output logic               busy,
   input  logic signed [15:0] req_start_x,
   input  logic signed [15:0] req_start_y,
   input  logic signed [15:0] req_move_x,
   input  logic signed [15:0] req_move_y,
   output logic               rsp_valid,
   output logic signed [15:0] rsp_new_x,
   output logic signed [15:0] rsp_new_y,
   output logic [1:0]         rsp_outcome,
   output logic [2:0]         rsp_wall_hit,
   input  logic               csr_we,
   input  logic [1:0]         csr_index,
   input  logic [14:0]        csr_wdata
);

   cfg_type cfg_ff, cfg_in;
   logic    s2_valid, s3_valid;
   s2_type  s2_data;
   s3_type  s3_data;

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_we) begin
         case (csr_index_type'(csr_index))
            CSR_X_MAX:    cfg_in.x_max = csr_wdata;
            CSR_Y_MAX:    cfg_in.y_max = csr_wdata;
            CSR_OBSTACLE: cfg_in.block = csr_wdata[0];
            default:      cfg_in = cfg_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.x_max <= X_MAX_RESET;
         cfg_ff.y_max <= Y_MAX_RESET;
         cfg_ff.block <= 1'b0;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   assign busy = 1'b0;

   awrm_front u_front (
      .clock    (clock),
      .reset    (reset),
      .cfg      (cfg_ff),
      .in_valid (start && !busy),
      .start_x  (req_start_x),
      .start_y  (req_start_y),
      .move_x   (req_move_x),
      .move_y   (req_move_y),
      .out_valid(s2_valid),
      .out_data (s2_data)
   );

   awrm_ray u_ray (
      .clock    (clock),
      .reset    (reset),
      .cfg      (cfg_ff),
      .in_valid (s2_valid),
      .in_data  (s2_data),
      .out_valid(s3_valid),
      .out_data (s3_data)
   );

   awrm_pick u_pick (
      .clock       (clock),
      .reset       (reset),
      .in_valid    (s3_valid),
      .in_data     (s3_data),
      .rsp_valid   (rsp_valid),
      .rsp_new_x   (rsp_new_x),
      .rsp_new_y   (rsp_new_y),
      .rsp_outcome (rsp_outcome),
      .rsp_wall_hit(rsp_wall_hit)
   );

endmodule

// ===== rtl/awrm_front.sv =====
`timescale 1ns / 1ps
module awrm_front
   import awrm_pkg::*;
(
   input  logic               clock,
   input  logic               reset,
   input  cfg_type            cfg,
   input  logic               in_valid,
   input  logic signed [15:0] start_x,
   input  logic signed [15:0] start_y,
   input  logic signed [15:0] move_x,
   input  logic signed [15:0] move_y,
   output logic               out_valid,
   output s2_type             out_data
);

   typedef struct packed {
      logic signed [16:0] px;
      logic signed [16:0] py;
      logic signed [15:0] sx;
      logic signed [15:0] sy;
      logic signed [16:0] qx;
      logic signed [16:0] qy;
      logic               free;
      logic               rev_ok;
      logic signed [17:0] n_left;
      logic signed [17:0] n_top;
      logic signed [17:0] n_right;
      logic signed [17:0] n_bottom;
      logic               mx_neg;
      logic               my_neg;
      logic               mx_nz;
      logic               my_nz;
      logic [15:0]        dx;
      logic [15:0]        dy;
   } s1_type;

   logic   v1_ff, v1_in;
   s1_type s1_ff, s1_in;
   logic   v2_ff, v2_in;
   s2_type s2_ff, s2_in;

   logic signed [17:0] a_left, a_right, a_top, a_bottom;
   logic               ok_left, ok_right, ok_top, ok_bottom;
   logic               pick_right, pick_bottom;

   // Stage 1: sums, differences and raw wall distances.
   always_comb begin
      s1_in.px       = 17'(start_x) + 17'(move_x);
      s1_in.py       = 17'(start_y) + 17'(move_y);
      s1_in.qx       = 17'(start_x) - 17'(move_x);
      s1_in.qy       = 17'(start_y) - 17'(move_y);
      s1_in.sx       = start_x;
      s1_in.sy       = start_y;
      s1_in.free     = in_arena(19'(s1_in.px), 19'(s1_in.py), cfg);
      s1_in.rev_ok   = in_arena(19'(s1_in.qx), 19'(s1_in.qy), cfg);
      s1_in.n_left   = 18'sd0 - 18'(start_x);
      s1_in.n_right  = $signed({3'b000, cfg.x_max}) - 18'(start_x);
      s1_in.n_top    = $signed({3'b000, cfg.y_max}) - 18'(start_y);
      s1_in.n_bottom = 18'sd0 - 18'(start_y);
      s1_in.mx_neg   = move_x[15];
      s1_in.my_neg   = move_y[15];
      s1_in.mx_nz    = (move_x != 16'sd0);
      s1_in.my_nz    = (move_y != 16'sd0);
      s1_in.dx       = move_x[15] ? 16'(17'sd0 - 17'(move_x)) : 16'(move_x);
      s1_in.dy       = move_y[15] ? 16'(17'sd0 - 17'(move_y)) : 16'(move_y);
      v1_in          = in_valid;
   end

   // Stage 2: orient distances along the move and keep the nearer wall per axis.
   always_comb begin
      a_left    = s1_ff.mx_neg ? -s1_ff.n_left   : s1_ff.n_left;
      a_right   = s1_ff.mx_neg ? -s1_ff.n_right  : s1_ff.n_right;
      a_top     = s1_ff.my_neg ? -s1_ff.n_top    : s1_ff.n_top;
      a_bottom  = s1_ff.my_neg ? -s1_ff.n_bottom : s1_ff.n_bottom;
      ok_left   = s1_ff.mx_nz && (a_left   > 18'sd0);
      ok_right  = s1_ff.mx_nz && (a_right  > 18'sd0);
      ok_top    = s1_ff.my_nz && (a_top    > 18'sd0);
      ok_bottom = s1_ff.my_nz && (a_bottom > 18'sd0);
      // lower wall index wins a tie on the same axis
      pick_right  = ok_right  && !(ok_left && (a_left <= a_right));
      pick_bottom = ok_bottom && !(ok_top  && (a_top  <= a_bottom));

      s2_in.px       = s1_ff.px;
      s2_in.py       = s1_ff.py;
      s2_in.sx       = s1_ff.sx;
      s2_in.sy       = s1_ff.sy;
      s2_in.qx       = s1_ff.qx;
      s2_in.qy       = s1_ff.qy;
      s2_in.free     = s1_ff.free;
      s2_in.rev_ok   = s1_ff.rev_ok;
      s2_in.vx       = ok_left || ok_right;
      s2_in.vy       = ok_top  || ok_bottom;
      s2_in.x_right  = pick_right;
      s2_in.y_bottom = pick_bottom;
      s2_in.num_x    = pick_right  ? 16'(a_right)  : 16'(a_left);
      s2_in.num_y    = pick_bottom ? 16'(a_bottom) : 16'(a_top);
      s2_in.dx       = s1_ff.dx;
      s2_in.dy       = s1_ff.dy;
      v2_in          = v1_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         v1_ff <= 1'b0;
         v2_ff <= 1'b0;
      end else begin
         v1_ff <= v1_in;
         v2_ff <= v2_in;
      end
   end

   always_ff @(posedge clock) begin
      s1_ff <= s1_in;
      s2_ff <= s2_in;
   end

   assign out_valid = v2_ff;
   assign out_data  = s2_ff;

endmodule

// ===== rtl/awrm_ray.sv =====
`timescale 1ns / 1ps
module awrm_ray
   import awrm_pkg::*;
(
   input  logic    clock,
   input  logic    reset,
   input  cfg_type cfg,
   input  logic    in_valid,
   input  s2_type  in_data,
   output logic    out_valid,
   output s3_type  out_data
);

   logic   v3_ff, v3_in;
   s3_type s3_ff, s3_in;

   // Stage 3: cross-multiply ray parameters, mirror in the per-axis wall.
   always_comb begin
      s3_in.px       = in_data.px;
      s3_in.py       = in_data.py;
      s3_in.sx       = in_data.sx;
      s3_in.sy       = in_data.sy;
      s3_in.qx       = in_data.qx;
      s3_in.qy       = in_data.qy;
      s3_in.free     = in_data.free;
      s3_in.rev_ok   = in_data.rev_ok;
      s3_in.vx       = in_data.vx;
      s3_in.vy       = in_data.vy;
      s3_in.x_right  = in_data.x_right;
      s3_in.y_bottom = in_data.y_bottom;
      // t_x < t_y  <=>  num_x * dy < num_y * dx
      s3_in.prod_x   = 32'(in_data.num_x) * 32'(in_data.dy);
      s3_in.prod_y   = 32'(in_data.num_y) * 32'(in_data.dx);
      s3_in.rfx      = in_data.x_right
                       ? $signed({3'b000, cfg.x_max, 1'b0}) - 19'(in_data.px)
                       : 19'sd0 - 19'(in_data.px);
      s3_in.rfy      = in_data.y_bottom
                       ? 19'sd0 - 19'(in_data.py)
                       : $signed({3'b000, cfg.y_max, 1'b0}) - 19'(in_data.py);
      s3_in.rfx_ok   = in_arena(s3_in.rfx, 19'(in_data.py), cfg);
      s3_in.rfy_ok   = in_arena(19'(in_data.px), s3_in.rfy, cfg);
      v3_in          = in_valid;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         v3_ff <= 1'b0;
      end else begin
         v3_ff <= v3_in;
      end
   end

   always_ff @(posedge clock) begin
      s3_ff <= s3_in;
   end

   assign out_valid = v3_ff;
   assign out_data  = s3_ff;

endmodule

// ===== rtl/awrm_pick.sv =====
`timescale 1ns / 1ps
`include "arena_wall_reflect_move_assert.svh"
module awrm_pick
   import awrm_pkg::*;
(
   input  logic               clock,
   input  logic               reset,
   input  logic               in_valid,
   input  s3_type             in_data,
   output logic               rsp_valid,
   output logic signed [15:0] rsp_new_x,
   output logic signed [15:0] rsp_new_y,
   output logic [1:0]         rsp_outcome,
   output logic [2:0]         rsp_wall_hit
);

   logic               rsp_valid_ff, rsp_valid_in;
   logic signed [15:0] rsp_new_x_ff, rsp_new_x_in;
   logic signed [15:0] rsp_new_y_ff, rsp_new_y_in;
   outcome_type        rsp_outcome_ff, rsp_outcome_in;
   wall_type           rsp_wall_ff, rsp_wall_in;

   logic     take_x;
   logic     any_wall;
   logic     refl_ok;
   wall_type wall_x, wall_y;

   // Stage 4: nearest wall over both axes, then the first point that lands inside.
   always_comb begin
      wall_x   = in_data.x_right  ? WALL_RIGHT  : WALL_LEFT;
      wall_y   = in_data.y_bottom ? WALL_BOTTOM : WALL_TOP;
      any_wall = in_data.vx || in_data.vy;
      if (in_data.vx && in_data.vy) begin
         if (in_data.prod_x < in_data.prod_y) begin
            take_x = 1'b1;
         end else if (in_data.prod_x == in_data.prod_y) begin
            // equal ray parameter: lower wall index wins, so left beats both
            // and right beats bottom but loses to top
            take_x = !in_data.x_right || in_data.y_bottom;
         end else begin
            take_x = 1'b0;
         end
      end else begin
         take_x = in_data.vx;
      end
      refl_ok = take_x ? in_data.rfx_ok : in_data.rfy_ok;

      // every point chosen other than the start lies inside the arena, so it fits 16 bits
      rsp_new_x_in   = in_data.sx;
      rsp_new_y_in   = in_data.sy;
      rsp_outcome_in = OUT_STAY;
      rsp_wall_in    = WALL_NONE;
      if (in_data.free) begin
         rsp_new_x_in   = 16'(in_data.px);
         rsp_new_y_in   = 16'(in_data.py);
         rsp_outcome_in = OUT_FREE;
      end else if (any_wall) begin
         rsp_wall_in = take_x ? wall_x : wall_y;
         if (refl_ok) begin
            rsp_new_x_in   = take_x ? 16'(in_data.rfx) : 16'(in_data.px);
            rsp_new_y_in   = take_x ? 16'(in_data.py)  : 16'(in_data.rfy);
            rsp_outcome_in = OUT_REFLECT;
         end else if (in_data.rev_ok) begin
            rsp_new_x_in   = 16'(in_data.qx);
            rsp_new_y_in   = 16'(in_data.qy);
            rsp_outcome_in = OUT_REVERSE;
         end
      end
      rsp_valid_in = in_valid;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      rsp_new_x_ff   <= rsp_new_x_in;
      rsp_new_y_ff   <= rsp_new_y_in;
      rsp_outcome_ff <= rsp_outcome_in;
      rsp_wall_ff    <= rsp_wall_in;
   end

   assign rsp_valid    = rsp_valid_ff;
   assign rsp_new_x    = rsp_new_x_ff;
   assign rsp_new_y    = rsp_new_y_ff;
   assign rsp_outcome  = rsp_outcome_ff;
   assign rsp_wall_hit = rsp_wall_ff;

   `AWRM_ASSERT_IMPL(a_free_has_no_wall, rsp_valid_ff && (rsp_outcome_ff == OUT_FREE), rsp_wall_ff == WALL_NONE)
   `AWRM_ASSERT_IMPL(a_bounce_has_wall, rsp_valid_ff && ((rsp_outcome_ff == OUT_REFLECT) || (rsp_outcome_ff == OUT_REVERSE)), rsp_wall_ff != WALL_NONE)
   `AWRM_ASSERT_IMPL(a_moved_x_positive, rsp_valid_ff && (rsp_outcome_ff != OUT_STAY), !rsp_new_x_ff[15] && (rsp_new_x_ff != 16'sd0))
   `AWRM_ASSERT_IMPL(a_moved_y_positive, rsp_valid_ff && (rsp_outcome_ff != OUT_STAY), !rsp_new_y_ff[15] && (rsp_new_y_ff != 16'sd0))

endmodule
